/* hdl/wfgs_pkg.sv */
// ----------------------------------------------------------------------------
// wfgs_pkg
// Shared types, register codes and constants of the water flow grid stencil.
// ----------------------------------------------------------------------------
package wfgs_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_LEVEL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SINK_LEVEL   = 2'd3;

  localparam logic [9:0]  GRID_WIDTH_RST   = 10'd64;
  localparam logic [12:0] GRID_HEIGHT_RST  = 13'd64;
  localparam logic [15:0] SOURCE_LEVEL_RST = 16'd25344;
  localparam logic [15:0] SINK_LEVEL_RST   = 16'd0;

  // Item kinds
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Wet average: sum of up to five waters, divided by a count of 1..5
  localparam int SUM_W       = 19;
  localparam int CNT_W       = 3;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;

  typedef struct packed {
    logic [15:0] water;
    logic [9:0]  land;
  } cell_t;

  // One column of the line store: the newer row and the row above it
  typedef struct packed {
    cell_t mid;
    cell_t up;
  } col_t;

  // Neighborhood of one emitted cell, right neighbor travels apart
  typedef struct packed {
    logic [8:0]  x;
    logic [11:0] y;
    logic        first;
    logic        last;
    logic        has_up;
    logic        has_left;
    logic        has_down;
    logic        has_right;
    cell_t       own;
    cell_t       up;
    cell_t       left;
    cell_t       down;
  } win_t;

  // Folded neighborhood: wet sum and count, dry maximum
  typedef struct packed {
    logic [8:0]       x;
    logic [11:0]      y;
    logic             first;
    logic             last;
    logic             dry;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [15:0]      big;
    logic [17:0]      land8;
    logic [15:0]      own;
  } mrg_t;

  // floor(2^RECIP_SHIFT / c) for the counts that occur
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [RECIP_W-1:0] r;
    unique case (c)
      3'd1:    r = 21'd1048576;
      3'd2:    r = 21'd524288;
      3'd3:    r = 21'd349525;
      3'd4:    r = 21'd262144;
      3'd5:    r = 21'd209715;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/wfgs_ifs.sv */
// ----------------------------------------------------------------------------
// wfgs_ifs
// Valid/ready channels for cell items and result items.
// ----------------------------------------------------------------------------
interface wfgs_cell_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] water_level;
  logic [9:0]  land_height;

  modport source (output valid, mode, water_level, land_height, input ready);
  modport sink   (input valid, mode, water_level, land_height, output ready);
endinterface

interface wfgs_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] new_water;
  logic [8:0]  cell_x;
  logic [11:0] cell_y;
  logic        frame_end;

  modport source (output valid, new_water, cell_x, cell_y, frame_end, input ready);
  modport sink   (input valid, new_water, cell_x, cell_y, frame_end, output ready);
endinterface

/* hdl/wfgs_window.sv */
// ----------------------------------------------------------------------------
// wfgs_window
// Raster counters, two-row line store and neighborhood register. Each column
// of the store is prefetched one item ahead, so the right neighbor of an
// emitted cell is the read that its own item starts.
// ----------------------------------------------------------------------------
module wfgs_window
  import wfgs_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [15:0]                        water_level,
  input  logic [9:0]                         land_height,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    h_eff,
  output logic                               win_valid,
  output win_t                               win,
  output cell_t                              right,
  input  logic                               win_ready
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WCW = $clog2(MAX_WIDTH+1);

  logic [XW-1:0]  col;
  logic [YW-1:0]  row;
  logic [WCW-1:0] fcnt;
  logic           draining;

  col_t           mem [MAX_WIDTH];
  col_t           rdata;
  col_t           fwd_data;
  col_t           pref;
  col_t           cur;
  col_t           wdata;
  logic           rd_pend;
  logic           fwd;
  cell_t          prev_mid;

  logic           accept;
  logic           is_cell;
  logic           is_flush;
  logic           col_wrap;
  logic           row_last;
  logic           f_in;
  logic           f_end;
  logic           op_cell;
  logic           op_flush;
  logic           rd_en;
  logic           emit;
  logic [XW-1:0]  rd_addr;
  logic [XW-1:0]  ex;
  logic [YW-1:0]  ey;
  win_t           win_next;

  assign in_ready = !win_valid || win_ready;
  assign accept   = in_valid && in_ready;
  assign is_cell  = (mode == MODE_CELL) && !draining;
  assign is_flush = (mode == MODE_FLUSH) && draining;

  // Boundary tests against the clamped geometry
  assign col_wrap = (32'(col) + 32'd1) >= 32'(w_eff);
  assign row_last = (32'(row) + 32'd1) >= 32'(h_eff);
  assign f_in     = 32'(fcnt) < 32'(w_eff);
  assign f_end    = !f_in || ((32'(fcnt) + 32'd1) >= 32'(w_eff));

  assign op_cell  = accept && is_cell;
  assign op_flush = accept && is_flush && f_in;
  assign rd_en    = op_cell || op_flush;
  assign emit     = (op_cell && (row != '0)) || op_flush;

  // Prefetch the next column: in cell mode wrap to column 0 at the row end
  always_comb begin
    if (is_cell) begin
      rd_addr = col_wrap ? '0 : XW'(32'(col) + 32'd1);
    end else begin
      rd_addr = XW'(32'(fcnt) + 32'd1);
    end
  end

  // Current column: fresh read, forwarded write, or held prefetch
  always_comb begin
    if (rd_pend) begin
      cur = fwd ? fwd_data : rdata;
    end else begin
      cur = pref;
    end
  end

  assign right = cur.mid;
  assign wdata = '{mid: '{water: water_level, land: land_height}, up: cur.mid};

  // Line store
  always_ff @(posedge clk) begin
    if (op_cell) begin
      mem[col] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Prefetch bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
    fwd      <= op_cell && (rd_addr == col);
    fwd_data <= wdata;
    pref     <= cur;
    if (rd_en) begin
      prev_mid <= cur.mid;
    end
  end

  // Build the neighborhood of the emitted cell
  always_comb begin
    ex = is_cell ? col : fcnt[XW-1:0];
    ey = is_cell ? (row - YW'(1)) : row;
    win_next.x         = 9'(ex);
    win_next.y         = 12'(ey);
    win_next.first     = (ex == '0) && (ey == '0);
    win_next.last      = ((32'(ex) + 32'd1) >= 32'(w_eff)) &&
                         ((32'(ey) + 32'd1) >= 32'(h_eff));
    win_next.has_up    = ey != '0;
    win_next.has_left  = ex != '0;
    win_next.has_down  = is_cell;
    win_next.has_right = (32'(ex) + 32'd1) < 32'(w_eff);
    win_next.own       = cur.mid;
    win_next.up        = cur.up;
    win_next.left      = prev_mid;
    win_next.down      = '{water: water_level, land: land_height};
  end

  // Advance the neighborhood register
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (in_ready) begin
      win_valid <= emit;
    end
    if (in_ready) begin
      win <= win_next;
    end
  end

  // Raster and flush counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      fcnt     <= '0;
      draining <= 1'b0;
    end else if (op_cell) begin
      if (col_wrap) begin
        col <= '0;
        if (row_last) begin
          draining <= 1'b1;
        end else begin
          row <= row + YW'(1);
        end
      end else begin
        col <= col + XW'(1);
      end
    end else if (accept && is_flush) begin
      if (f_end) begin
        fcnt     <= '0;
        row      <= '0;
        col      <= '0;
        draining <= 1'b0;
      end else begin
        fcnt <= fcnt + WCW'(1);
      end
    end
  end

endmodule

/* hdl/wfgs_merge.sv */
// ----------------------------------------------------------------------------
// wfgs_merge
// Folds the four neighbors into a wet sum and count or a dry maximum.
// ----------------------------------------------------------------------------
module wfgs_merge
  import wfgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  win_valid,
  output logic  win_ready,
  input  win_t  win,
  input  cell_t right,
  output logic  mrg_valid,
  output mrg_t  mrg,
  input  logic  mrg_ready
);

  cell_t            nb  [4];
  logic             has [4];
  logic [17:0]      land8;
  logic [17:0]      nl8;
  logic             dry;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      big;
  mrg_t             mrg_next;

  assign win_ready = !mrg_valid || mrg_ready;

  // Neighbor order: up, left, down, right
  always_comb begin
    nb[0]  = win.up;
    nb[1]  = win.left;
    nb[2]  = win.down;
    nb[3]  = right;
    has[0] = win.has_up;
    has[1] = win.has_left;
    has[2] = win.has_down;
    has[3] = win.has_right;
  end

  // Fold the neighbors
  always_comb begin
    land8 = {win.own.land, 8'h00};
    dry   = {2'b00, win.own.water} <= land8;
    sum   = SUM_W'(win.own.water);
    cnt   = CNT_W'(1);
    big   = '0;
    nl8   = '0;
    for (int i = 0; i < 4; i++) begin
      nl8 = {nb[i].land, 8'h00};
      if (has[i]) begin
        if (!dry) begin
          if (nl8 < {2'b00, win.own.water}) begin
            sum = sum + SUM_W'(nb[i].water);
            cnt = cnt + CNT_W'(1);
          end
        end else if (({2'b00, nb[i].water} > nl8) && (nb[i].water > big)) begin
          big = nb[i].water;
        end
      end
    end
    mrg_next.x     = win.x;
    mrg_next.y     = win.y;
    mrg_next.first = win.first;
    mrg_next.last  = win.last;
    mrg_next.dry   = dry;
    mrg_next.sum   = sum;
    mrg_next.cnt   = cnt;
    mrg_next.big   = big;
    mrg_next.land8 = land8;
    mrg_next.own   = win.own.water;
  end

  // Advance
  always_ff @(posedge clk) begin
    if (rst) begin
      mrg_valid <= 1'b0;
    end else if (win_ready) begin
      mrg_valid <= win_valid;
    end
    if (win_ready) begin
      mrg <= mrg_next;
    end
  end

endmodule

/* hdl/wfgs_finish.sv */
// ----------------------------------------------------------------------------
// wfgs_finish
// Divides the wet sum by its count through a reciprocal multiply, corrects
// the quotient, picks the dry rule and the forced levels, holds the result.
// ----------------------------------------------------------------------------
module wfgs_finish
  import wfgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        mrg_valid,
  output logic        mrg_ready,
  input  mrg_t        mrg,
  input  logic [15:0] source_level,
  input  logic [15:0] sink_level,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [15:0] new_water,
  output logic [8:0]  cell_x,
  output logic [11:0] cell_y,
  output logic        frame_end
);

  logic                     v3;
  logic                     en3;
  logic                     en4;
  mrg_t                     m3;
  logic [SUM_W-1:0]         q3;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [SUM_W-1:0]         qc;
  logic [SUM_W-1:0]         rem;
  logic [SUM_W-1:0]         wet_q;
  logic [SUM_W-1:0]         dry_mean;
  logic [15:0]              nw;

  assign en4       = !res_valid || res_ready;
  assign en3       = !v3 || en4;
  assign mrg_ready = en3;

  assign prod = (SUM_W+RECIP_W)'(mrg.sum) * (SUM_W+RECIP_W)'(recip(mrg.cnt));

  // Estimate the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= mrg_valid;
    end
    if (en3) begin
      m3 <= mrg;
      q3 <= prod[RECIP_SHIFT +: SUM_W];
    end
  end

  // Correct the estimate and select the new water
  always_comb begin
    qc       = q3 * SUM_W'(m3.cnt);
    rem      = m3.sum - qc;
    wet_q    = (rem >= SUM_W'(m3.cnt)) ? (q3 + SUM_W'(1)) : q3;
    dry_mean = (SUM_W'(m3.big) + SUM_W'(m3.land8)) >> 1;
    if (!m3.dry) begin
      nw = wet_q[15:0];
    end else if ({2'b00, m3.big} >= m3.land8) begin
      nw = dry_mean[15:0];
    end else begin
      nw = m3.own;
    end
    if (m3.first) begin
      nw = source_level;
    end
    if (m3.last) begin
      nw = sink_level;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en4) begin
      res_valid <= v3;
    end
    if (en4) begin
      new_water <= nw;
      cell_x    <= m3.x;
      cell_y    <= m3.y;
      frame_end <= m3.last;
    end
  end

endmodule

/* hdl/water_flow_grid_stencil.sv */
// Throughput: one item per clock unless result stalls; the line store takes
//   one write and one prefetch read per item; every stage advances on its own.
// Path: a cell's result is computed after the item directly below it (or its
//   flush item) is accepted, through the window register (loaded on the accept
//   edge), then the fold, multiply and output registers.
// Reset (rst, synchronous): clears counters, valid bits and configuration
//   registers to their defaults; the line store and data registers are not cleared.
// ----------------------------------------------------------------------------
// water_flow_grid_stencil
// One generation of water flow over terrain, streamed as a raster stencil.
// ----------------------------------------------------------------------------
module water_flow_grid_stencil
  import wfgs_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  wfgs_cell_if.sink              cells,
  wfgs_result_if.source          result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WCW = $clog2(MAX_WIDTH+1);
  localparam int HCW = $clog2(MAX_HEIGHT+1);

  logic [9:0]     grid_width;
  logic [12:0]    grid_height;
  logic [15:0]    source_level;
  logic [15:0]    sink_level;
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;

  logic           win_valid;
  logic           win_ready;
  win_t           win;
  cell_t          right;
  logic           mrg_valid;
  logic           mrg_ready;
  mrg_t           mrg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= GRID_WIDTH_RST;
      grid_height  <= GRID_HEIGHT_RST;
      source_level <= SOURCE_LEVEL_RST;
      sink_level   <= SINK_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:   grid_width   <= cfg_data[9:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[12:0];
        REG_SOURCE_LEVEL: source_level <= cfg_data;
        REG_SINK_LEVEL:   sink_level   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp geometry to 1..max
  always_comb begin
    if (grid_width == '0) begin
      w_eff = WCW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = HCW'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(grid_height);
    end
  end

  wfgs_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cells.valid),
    .in_ready    (cells.ready),
    .mode        (cells.mode),
    .water_level (cells.water_level),
    .land_height (cells.land_height),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .win_valid   (win_valid),
    .win         (win),
    .right       (right),
    .win_ready   (win_ready)
  );

  wfgs_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .right     (right),
    .mrg_valid (mrg_valid),
    .mrg       (mrg),
    .mrg_ready (mrg_ready)
  );

  wfgs_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .mrg_valid    (mrg_valid),
    .mrg_ready    (mrg_ready),
    .mrg          (mrg),
    .source_level (source_level),
    .sink_level   (sink_level),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .new_water    (result.new_water),
    .cell_x       (result.cell_x),
    .cell_y       (result.cell_y),
    .frame_end    (result.frame_end)
  );

  // Input back-pressure only arises from a held result
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !cells.ready |-> result.valid)
    else $error("input stalled with no result waiting");

  // Reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> cells.ready)
    else $error("input not ready right after reset");

endmodule
